// ===== rtl/core/mrpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared types and constants for the Miller-Rabin primality tester.
// ----------------------------------------------------------------------------
package mrpt_pkg;

	localparam int NBits     = 49;
	localparam int BaseCount = 7;
	localparam int CntBits   = 6;

	typedef logic [NBits-1:0] word_t;

	// Witness bases, first NumBases are used
	function automatic word_t witness_base(input logic [2:0] idx);
		word_t r;
		r = '0;
		case (idx)
			3'd0:    r = word_t'(2);
			3'd1:    r = word_t'(3);
			3'd2:    r = word_t'(5);
			3'd3:    r = word_t'(7);
			3'd4:    r = word_t'(11);
			3'd5:    r = word_t'(13);
			3'd6:    r = word_t'(17);
			default: r = word_t'(17);
		endcase
		return r;
	endfunction

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_BASE,
		ST_POW_MUL,
		ST_POW_SQR,
		ST_POW_NEXT,
		ST_CHECK,
		ST_SQ_MUL,
		ST_DONE
	} state_t;

	// Request to the modular multiplier
	typedef struct packed {
		logic  start;
		word_t x;
		word_t y;
		word_t m;
	} mul_req_t;

	typedef struct packed {
		logic  done;
		word_t p;
	} mul_rsp_t;

endpackage

// ===== rtl/core/mrpt_modmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_modmul
// Bit-serial shift-and-add modular multiplier, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module mrpt_modmul import mrpt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [NBits:0]    acc_q;
	logic [NBits:0]    add_q;
	word_t             y_q;
	word_t             m_q;
	logic [NBits:0]    acc_sum;
	logic [NBits:0]    add_dbl;
	logic [NBits:0]    acc_nx;
	logic [NBits:0]    add_nx;

	// operands stay below m, so one conditional subtract suffices
	always_comb begin
		acc_sum = acc_q + add_q;
		acc_nx  = acc_q;
		if (y_q[0]) begin
			acc_nx = (acc_sum >= {1'b0, m_q}) ? acc_sum - {1'b0, m_q} : acc_sum;
		end
		add_dbl = {add_q[NBits-1:0], 1'b0};
		add_nx  = (add_dbl >= {1'b0, m_q}) ? add_dbl - {1'b0, m_q} : add_dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && y_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			add_q <= {1'b0, req.x};
			y_q   <= req.y;
			m_q   <= req.m;
		end else if (busy_q && y_q != '0) begin
			acc_q <= acc_nx;
			add_q <= add_nx;
			y_q   <= {1'b0, y_q[NBits-1:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = acc_q[NBits-1:0];

endmodule

// ===== rtl/core/mrpt_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrpt_seq
// Sequencer: splits n-1, walks the bases, drives the shared multiplier.
// ----------------------------------------------------------------------------
module mrpt_seq import mrpt_pkg::*; #(
	parameter int NumBases = BaseCount
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  word_t    n_in,
	output logic     busy,
	output logic     done,
	output logic     verdict,
	output mul_req_t req,
	input  mul_rsp_t rsp
);

	localparam int UseBases = (NumBases > BaseCount) ? BaseCount : NumBases;

	state_t state_q, state_d;
	word_t  n_q, d_q, e_q, x_q, sq_q;
	logic [CntBits-1:0] s_q, r_q;
	logic [2:0] bi_q;
	logic   prime_q;
	word_t  base_a;
	word_t  nm1;
	logic   bases_left;
	logic   base_pass;

	assign nm1        = n_q - word_t'(1);
	assign base_a     = witness_base(bi_q);
	assign bases_left = (4'(bi_q) < 4'(UseBases)) && (base_a < n_q);
	// a^d == 1 passes only before any squaring; n-1 passes at any round
	assign base_pass  = (x_q == word_t'(1) && r_q == '0) || x_q == nm1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (start) state_d = ST_SPLIT;
			ST_SPLIT: begin
				if (n_q == word_t'(2)) state_d = ST_DONE;
				else if (n_q <= word_t'(1) || !n_q[0]) state_d = ST_DONE;
				else if (d_q[0]) state_d = ST_BASE;
			end
			ST_BASE:     state_d = bases_left ? ST_POW_NEXT : ST_DONE;
			ST_POW_NEXT: begin
				if (e_q == '0) state_d = ST_CHECK;
				else if (e_q[0]) state_d = ST_POW_MUL;
				else state_d = ST_POW_SQR;
			end
			ST_POW_MUL:  if (rsp.done) state_d = ST_POW_SQR;
			ST_POW_SQR:  if (rsp.done) state_d = ST_POW_NEXT;
			ST_CHECK: begin
				if (base_pass) state_d = ST_BASE;
				else if (r_q + 1'b1 >= s_q) state_d = ST_DONE;
				else state_d = ST_SQ_MUL;
			end
			ST_SQ_MUL:   if (rsp.done) state_d = ST_CHECK;
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.start = 1'b0;
		req.x     = x_q;
		req.y     = sq_q;
		req.m     = n_q;
		busy      = (state_q != ST_IDLE);
		done      = (state_q == ST_DONE);
		verdict   = prime_q;
		case (state_q)
			ST_POW_NEXT: begin
				req.start = (e_q != '0);
				req.x     = e_q[0] ? x_q : sq_q;
			end
			ST_POW_MUL: begin
				req.start = rsp.done;
				req.x     = sq_q;
			end
			ST_CHECK: begin
				req.start = (state_d == ST_SQ_MUL);
				req.y     = x_q;
			end
			default: req.start = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q     <= n_in;
				d_q     <= n_in - word_t'(1);
				s_q     <= '0;
				bi_q    <= '0;
				prime_q <= 1'b1;
			end
			ST_SPLIT: begin
				if (n_q == word_t'(2)) prime_q <= 1'b1;
				else if (n_q <= word_t'(1) || !n_q[0]) prime_q <= 1'b0;
				else if (!d_q[0]) begin
					d_q <= {1'b0, d_q[NBits-1:1]};
					s_q <= s_q + 1'b1;
				end
			end
			ST_BASE: begin
				e_q  <= d_q;
				x_q  <= word_t'(1);
				sq_q <= base_a;
				r_q  <= '0;
			end
			ST_POW_MUL: if (rsp.done) x_q <= rsp.p;
			ST_POW_SQR: if (rsp.done) begin
				sq_q <= rsp.p;
				e_q  <= {1'b0, e_q[NBits-1:1]};
			end
			ST_CHECK: begin
				if (base_pass) bi_q <= bi_q + 1'b1;
				else if (r_q + 1'b1 >= s_q) prime_q <= 1'b0;
			end
			ST_SQ_MUL: if (rsp.done) begin
				x_q <= rsp.p;
				r_q <= r_q + 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/miller_rabin_primality_test_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_primality_test_top
// Deterministic Miller-Rabin primality tester on stream ports.
// ----------------------------------------------------------------------------
// One 49-bit n per input transfer, one prime flag bit per output transfer.
// Bases 2,3,5,7,11,13,17 (first NumBases) make the test exact below
// 341550071728321. All arithmetic runs through one bit-serial modular
// multiplier; a full test costs roughly NumBases * 2*49 products, plus
// stripping factors of two from n-1. Trivial inputs (even, <=1, 2)
// skip the multiplier. s_tready is low while a test runs; the result
// sits in an output register until taken, and the next item is taken only
// after that.
module miller_rabin_primality_test_top import mrpt_pkg::*; #(
	parameter int NumBases = BaseCount
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // [48:0] n_value, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [0] prime flag, rest zero
);

	mul_req_t req;
	mul_rsp_t rsp;
	logic     busy, done, verdict, start;
	logic     out_valid_q, out_bit_q;

	// accept only when the engine idles and no result is pending
	assign s_tready = !busy && !out_valid_q;
	assign start    = s_tvalid && s_tready;

	mrpt_seq #(.NumBases(NumBases)) u_seq (
		.clk(clk), .arst_n(arst_n), .start(start), .n_in(s_tdata[NBits-1:0]),
		.busy(busy), .done(done), .verdict(verdict), .req(req), .rsp(rsp)
	);

	mrpt_modmul u_mul (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_bit_q <= verdict;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0, out_bit_q};

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready) else $error("input taken during a test");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !out_valid_q) else $error("result overwrites pending result");
	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy) else $error("accepted item did not start a test");

endmodule

// ===== sim/miller_rabin_primality_test_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_primality_test_top_tb
// Stream-level check of the Miller-Rabin primality tester.
// ----------------------------------------------------------------------------
// A short table of directed values (trivial inputs, small primes and
// composites, strong pseudoprimes, the top of the 49-bit range) is followed
// by random values, most of them odd. Every transfer on the input side is
// run through a local square-and-multiply predictor, and each output
// transfer is compared with the oldest predicted verdict.
module miller_rabin_primality_test_top_tb import mrpt_pkg::*; ;

	localparam int NumRandom = 80;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;   // [48:0] n_value, rest zero
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [0] prime flag, rest zero

	// Idle chances in percent, changed per phase
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	bit verdict_q[$];   // predicted prime flags, oldest first
	int errors;

	// Directed rows: value, and a known verdict where one is obvious
	typedef struct {
		word_t n;
		bit    known;
		bit    prime;
	} row_t;

	row_t rows[$];

	miller_rabin_primality_test_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop; 102 items, both sides stalling
	initial begin
		#(64'd4 * 64'd20_000_000);
		$display("miller_rabin_primality_test_top test failed");
		$finish;
	end

	task automatic report_mismatch(input string what);
		errors++;
		$display("ERROR %0t: %s", $time, what);
	endtask

	function automatic void add_row(input word_t n, input bit known, input bit prime);
		row_t r;
		r.n     = n;
		r.known = known;
		r.prime = prime;
		rows.insert(rows.size(), r);
	endfunction

	// (x * y) mod m, shift and add; 50 bits keeps sums from overflowing
	function automatic word_t mulmod(input word_t x, input word_t y, input word_t m);
		logic [NBits:0] acc, add;
		word_t yy;
		acc = '0;
		add = x % m;
		yy  = y;
		while (yy != 0) begin
			if (yy[0]) begin
				acc = acc + add;
				if (acc >= m) acc = acc - m;
			end
			add = add + add;
			if (add >= m) add = add - m;
			yy = yy >> 1;
		end
		return word_t'(acc);
	endfunction

	function automatic word_t powmod(input word_t b, input word_t e, input word_t m);
		word_t res, sq, ee;
		res = 1;
		sq  = b % m;
		ee  = e;
		while (ee != 0) begin
			if (ee[0]) res = mulmod(res, sq, m);
			sq = mulmod(sq, sq, m);
			ee = ee >> 1;
		end
		return res;
	endfunction

	function automatic bit predict_prime(input word_t n);
		word_t d, x, a;
		int s, i, r;
		bit witness_ok;
		if (n == 2) return 1'b1;
		if (n <= 1 || !n[0]) return 1'b0;
		d = n - 1;
		s = 0;
		while (!d[0]) begin
			d = d >> 1;
			s++;
		end
		for (i = 0; i < BaseCount; i++) begin
			a = witness_base(3'(i));
			if (a >= n) break;
			x = powmod(a, d, n);
			if (x == 1) continue;
			witness_ok = 1'b0;
			for (r = 0; r < s; r++) begin
				if (x == n - 1) begin
					witness_ok = 1'b1;
					break;
				end
				x = mulmod(x, x, n);
			end
			if (!witness_ok) return 1'b0;
		end
		return 1'b1;
	endfunction

	// One input transfer; the prediction is queued at the accepting edge.
	// tvalid stays high after the transfer; the caller or the next idle drops it.
	task automatic send_value(input word_t n, input bit known, input bit prime);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, n};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (known && predict_prime(n) != prime)
			report_mismatch($sformatf("table verdict for %0d disagrees with predictor", n));
		verdict_q.insert(verdict_q.size(), known ? prime : predict_prime(n));
	endtask

	function automatic word_t random_value();
		word_t n;
		n = word_t'({$urandom, $urandom});
		// Small sizes half the time keep runs short; otherwise full width
		case ($urandom_range(3))
			0: n = n & word_t'(16'hffff);
			1: n = n & word_t'(32'hffff_ffff);
			default: ;
		endcase
		if ($urandom_range(9) != 0) n[0] = 1'b1;   // mostly odd, the real work
		return n;
	endfunction

	// Receiver: random stalls, checks every output transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("result with none expected");
				end else begin
					bit exp_prime;
					exp_prime = verdict_q.pop_front();
					if (m_tdata[0] !== exp_prime)
						report_mismatch($sformatf("prime flag %b, expected %b",
							m_tdata[0], exp_prime));
					if (m_tdata[7:1] !== 7'd0)
						report_mismatch("nonzero padding in m_tdata");
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		word_t top;
		int k, ph;
		top = '1;
		errors = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		send_idle_pct = 16;
		recv_idle_pct = 49;

		// trivial inputs and extremes have verdicts readable at a glance
		add_row(word_t'(0), 1, 0);
		add_row(word_t'(1), 1, 0);
		add_row(word_t'(2), 1, 1);
		add_row(word_t'(3), 1, 1);
		add_row(word_t'(4), 1, 0);
		add_row(word_t'(5), 1, 1);
		add_row(word_t'(9), 1, 0);
		add_row(word_t'(17), 1, 1);
		add_row(word_t'(19), 1, 1);
		add_row(top - 1, 1, 0);                  // even, all bits but one
		// strong pseudoprimes to the first few bases, a Carmichael, primes
		add_row(word_t'(2047), 0, 0);
		add_row(word_t'(561), 0, 0);
		add_row(word_t'(1373653), 0, 0);
		add_row(word_t'(25326001), 0, 0);
		add_row(word_t'(64'd3215031751), 0, 0);
		add_row(word_t'(64'd2152302898747), 0, 0);
		add_row(word_t'(64'd3474749660383), 0, 0);
		add_row(word_t'(64'd341550071728321), 0, 0); // at the exact bound
		add_row(word_t'(64'd341550071728320), 0, 0); // top of exact range
		add_row(word_t'(65537), 0, 0);
		add_row(word_t'(64'd4294967291), 0, 0);
		add_row(top, 0, 0);                      // every bit set
		add_row(word_t'(64'h0_aaaa_aaaa_aaab), 0, 0);
		add_row(word_t'(64'h1_5555_5555_5555), 0, 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_value(rows[i].n, rows[i].known, rows[i].prime);
		s_tvalid <= 1'b0;

		// Hold off until the directed results have all drained
		while (verdict_q.size() != 0) @(posedge clk);

		// Three idle phases: receiver-heavy, sender-heavy swap, then none
		for (ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 49 : 0;
			recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 16 : 0;
			for (k = 0; k < NumRandom / 3; k++)
				send_value(random_value(), 1'b0, 1'b0);
		end
		s_tvalid <= 1'b0;

		while (verdict_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		if (errors == 0) begin
			$display("miller_rabin_primality_test_top test passed");
		end else begin
			$display("miller_rabin_primality_test_top test failed");
		end
		$finish;
	end

endmodule
